// File: rtl/core/kldma_pkg.sv
// Shared types and constants for the KL divergence mean accumulator.
// No dependencies; imported by the front, back and top level.
`default_nettype none

package kldma_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned PredW  = 32;
  localparam int unsigned AccW   = 48;
  localparam int unsigned RowW   = 11;

  // ln(2) in Q0.32
  localparam logic [31:0] Ln2Q32 = 32'hB17217F8;

  // One queued matrix entry, tagged by the front
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [PredW-1:0]  pred;
    logic              last;
    logic              skip;
  } entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOG,
    B_LN,
    B_TERM,
    B_ACC,
    B_DSET,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

`default_nettype wire

// File: rtl/core/kldma_front.sv
// Front end: accepts matrix entries, flags entries with a zero count or prediction, holds a two-entry queue.
// Depends on kldma_pkg.
`default_nettype none

module kldma_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [47:0]         s_tdata,   // observed_count[15:0], predicted_value[47:16]
  input  wire logic                s_tlast,   // last_entry
  output kldma_pkg::entry_t        head,
  output logic                     head_valid,
  input  wire logic                pop
);
  import kldma_pkg::*;

  entry_t     slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       push;
  entry_t     incoming;

  // Classify: a zero count or zero prediction adds nothing
  always_comb begin
    incoming.count = s_tdata[15:0];
    incoming.pred  = s_tdata[47:16];
    incoming.last  = s_tlast;
    incoming.skip  = (s_tdata[15:0] == '0) || (s_tdata[47:16] == '0);
  end

  assign s_tready   = (fill != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign head       = slot[rp];
  assign head_valid = (fill != 2'd0);

  // Write the incoming transfer into the queue
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= incoming;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/kldma_log2.sv
// Iterative fixed-point log2: one squaring step per fraction bit.
// Standalone; used twice by kldma_back.
`default_nettype none

module kldma_log2 #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [31:0]                x,
  output logic                            done,
  output logic [4+FRACTION_BITS:0]        result
);

  localparam int unsigned CntW = $clog2(FRACTION_BITS);

  logic                     busy;
  logic                     norm;
  logic [4:0]               e;
  logic [31:0]              xr;
  logic [31:0]              m;
  logic [FRACTION_BITS-1:0] frac;
  logic [CntW-1:0]          cnt;
  logic [4:0]               e_next;
  logic [63:0]              sq;
  logic [32:0]              t;
  logic [31:0]              m_next;

  // Index of the leading one
  always_comb begin
    e_next = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        e_next = 5'(i);
      end
    end
  end

  // One squaring step of the mantissa
  always_comb begin
    sq     = 64'(m) * 64'(m);
    t      = sq[63:31];
    m_next = t[32] ? t[32:1] : t[31:0];
  end

  assign result = {e, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      norm <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      norm <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (norm) begin
        norm <= 1'b0;
      end else if (cnt == CntW'(FRACTION_BITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: normalise, then square once per fraction bit
  always_ff @(posedge clk) begin
    if (start) begin
      xr <= x;
      e  <= e_next;
    end else if (busy) begin
      if (norm) begin
        m    <= xr << (5'd31 - e);
        frac <= '0;
        cnt  <= '0;
      end else begin
        m    <= m_next;
        frac <= {frac[FRACTION_BITS-2:0], t[32]};
        cnt  <= cnt + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/kldma_back.sv
// Back end: log terms, saturating accumulation, mean by restoring division.
// Depends on kldma_pkg and kldma_log2.
`default_nettype none

module kldma_back #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire kldma_pkg::entry_t            head,
  input  wire logic                         head_valid,
  output logic                              pop,
  input  wire logic [kldma_pkg::RowW-1:0]   row_count,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [47:0]                       m_tdata,   // mean_divergence[47:0]
  output logic                              m_tuser    // overflowed
);
  import kldma_pkg::*;

  localparam int unsigned LogW = 5 + FRACTION_BITS;

  back_state_t           state;
  back_state_t           state_next;
  logic                  log_start;
  logic                  load_out;

  logic                  done_a;
  logic                  done_b;
  logic [LogW-1:0]       log_a;
  logic [LogW-1:0]       log_b;

  logic [CountW-1:0]     count;
  logic                  last;
  logic                  neg;
  logic [LogW-1:0]       mag;
  logic [LogW+31:0]      prod1;
  logic [LogW+15:0]      prod2;
  logic signed [AccW-1:0] total;
  logic                  sat;

  logic [AccW-1:0]       dq;
  logic [RowW-1:0]       rem;
  logic [RowW-1:0]       divisor;
  logic                  qneg;
  logic [5:0]            step;

  logic signed [LogW:0]  d;
  logic [LogW+31:0]      rounded;
  logic signed [AccW:0]  term;
  logic signed [AccW:0]  sum;
  logic [RowW:0]         r2;
  logic                  ge;

  kldma_log2 #(.FRACTION_BITS(FRACTION_BITS)) u_log_count (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .x      ({head.count, 16'h0000}),
    .done   (done_a),
    .result (log_a)
  );

  kldma_log2 #(.FRACTION_BITS(FRACTION_BITS)) u_log_pred (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .x      (head.pred),
    .done   (done_b),
    .result (log_b)
  );

  // Datapath arithmetic
  always_comb begin
    d       = $signed({1'b0, log_a}) - $signed({1'b0, log_b});
    rounded = prod1 + (LogW+32)'(64'h80000000);
    term    = $signed((AccW+1)'(prod2));
    if (neg) begin
      term = -term;
    end
    sum = $signed({total[AccW-1], total}) + term;
    r2  = {rem, dq[AccW-1]};
    ge  = (r2 >= {1'b0, divisor});
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (head_valid) begin
          if (head.skip) begin
            state_next = head.last ? B_DSET : B_IDLE;
          end else begin
            state_next = B_LOG;
          end
        end
      end
      B_LOG:  if (done_a && done_b) state_next = B_LN;
      B_LN:   state_next = B_TERM;
      B_TERM: state_next = B_ACC;
      B_ACC:  state_next = last ? B_DSET : B_IDLE;
      B_DSET: state_next = B_DIV;
      B_DIV:  if (step == 6'(AccW - 1)) state_next = B_OUT;
      B_OUT:  if (!m_tvalid || m_tready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop       = (state == B_IDLE) && head_valid;
    log_start = pop && !head.skip;
    load_out  = (state == B_OUT) && (!m_tvalid || m_tready);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      total    <= '0;
      sat      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_ACC) begin
        if (!sum[AccW] && sum[AccW-1]) begin
          total <= {1'b0, {(AccW-1){1'b1}}};
          sat   <= 1'b1;
        end else if (sum[AccW] && !sum[AccW-1]) begin
          total <= {1'b1, {(AccW-1){1'b0}}};
          sat   <= 1'b1;
        end else begin
          total <= sum[AccW-1:0];
        end
      end else if (load_out) begin
        total <= '0;
        sat   <= 1'b0;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      count <= head.count;
      last  <= head.last;
    end
    case (state)
      B_LOG: begin
        neg <= d[LogW];
        mag <= d[LogW] ? LogW'(-d) : d[LogW-1:0];
      end
      B_LN:   prod1 <= (LogW+32)'(mag) * (LogW+32)'(Ln2Q32);
      B_TERM: prod2 <= (LogW+16)'(rounded[LogW+31:32]) * (LogW+16)'(count);
      B_DSET: begin
        qneg    <= total[AccW-1];
        dq      <= total[AccW-1] ? -total : total;
        rem     <= '0;
        divisor <= (row_count == '0) ? RowW'(1) : row_count;
        step    <= '0;
      end
      B_DIV: begin
        rem  <= ge ? RowW'(r2 - {1'b0, divisor}) : r2[RowW-1:0];
        dq   <= {dq[AccW-2:0], ge};
        step <= step + 6'd1;
      end
      default: ;
    endcase
    if (load_out) begin
      m_tdata <= qneg ? -dq : dq;
      m_tuser <= sat;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/kl_divergence_mean_accumulator.sv
// Top level of the KL divergence mean accumulator: config register, front, back.
// Depends on kldma_pkg, kldma_front, kldma_back (and kldma_log2 through it).
//
//   channel   dir  data                                  side band
//   s_*       in   observed_count, predicted_value       tlast = last_entry
//   m_*       out  mean_divergence                       tuser = overflowed
//   cfg_*     in   row_count                             write only
//
// A non-zero entry's time in the back end is set by the squaring loop of the two
// log2 units running side by side; a zero entry skips them. A last entry adds the
// bit-serial division by row_count.
// The two-entry queue takes up to two entries while the back end works or the result waits.
// Reset (rst, synchronous) clears the total, the flag and sets row_count to 20.
`default_nettype none

module kl_divergence_mean_accumulator #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // observed_count[15:0], predicted_value[47:16]
  input  wire logic        s_tlast,   // last_entry
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // mean_divergence[47:0]
  output logic             m_tuser,   // overflowed
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata  // row_count
);
  import kldma_pkg::*;

  logic [RowW-1:0] row_count;
  entry_t          head;
  logic            head_valid;
  logic            pop;

  // Hold the row count register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= RowW'(20);
    end else if (cfg_we) begin
      row_count <= cfg_wdata;
    end
  end

  kldma_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  kldma_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .row_count  (row_count),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire
